### sv/assert_macros.svh
// Assertion macros shared by the quaternion-to-matrix RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of i_clk, off while i_rst_n is low.
`define QXRM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check that a condition never holds.
`define QXRM_NEVER(lbl, cond, msg) \
    `QXRM_ASSERT(lbl, !(cond), msg)

`endif

### sv/qxrm_pkg.sv
// Shared types, widths and helpers for the quaternion-to-matrix pipeline.
`default_nettype none

package qxrm_pkg;

    localparam int IN_W   = 16;
    localparam int PROD_W = 32;
    localparam int SUM_W  = 34;
    localparam int RAD_W  = 30;
    localparam int ROOT_W = 15;

    localparam logic [ROOT_W-1:0] ROOT_MAX = {ROOT_W{1'b1}};

    // Payload carried alongside the square root: inputs and raw products
    typedef struct packed {
        logic signed [IN_W-1:0]   x;
        logic signed [IN_W-1:0]   y;
        logic signed [IN_W-1:0]   z;
        logic signed [PROD_W-1:0] p_xx;
        logic signed [PROD_W-1:0] p_yy;
        logic signed [PROD_W-1:0] p_zz;
        logic signed [PROD_W-1:0] p_xy;
        logic signed [PROD_W-1:0] p_xz;
        logic signed [PROD_W-1:0] p_yz;
    } t_side;

    // Clamp a wide sum to the signed 16-bit range
    function automatic logic signed [IN_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
        if (v > 34'sd32767) begin
            return 16'sh7fff;
        end else if (v < -34'sd32768) begin
            return 16'sh8000;
        end
        return v[IN_W-1:0];
    endfunction

endpackage

`default_nettype wire

### sv/qxrm_isqrt.sv
// Pipelined integer square root, one result bit per stage, with side payload.
`default_nettype none
`include "assert_macros.svh"

module qxrm_isqrt
    import qxrm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [RAD_W-1:0]  i_rad,
    input  wire logic              i_sat,
    input  wire t_side             i_side,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [ROOT_W-1:0]      o_root,
    output t_side                  o_side
);

    localparam int STAGES = ROOT_W;

    typedef struct packed {
        logic [RAD_W-1:0] rem;
        logic [RAD_W-1:0] res;
        logic             sat;
        t_side            side;
    } t_sq_stage;

    t_sq_stage r_stg [STAGES];
    logic      r_vld [STAGES];
    t_sq_stage w_in  [STAGES];
    t_sq_stage n_stg [STAGES];
    logic      w_vin [STAGES];
    logic      w_rdy [STAGES+1];

    assign w_rdy[STAGES] = i_ready;
    assign o_ready       = w_rdy[0];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (STAGES - 1 - k));

        logic [RAD_W:0] w_trial;
        logic           w_ge;

        // Pick up the previous stage, or the port for the first one
        if (k == 0) begin : g_first
            assign w_in[k]  = '{rem: i_rad, res: '0, sat: i_sat, side: i_side};
            assign w_vin[k] = i_valid;
        end else begin : g_next
            assign w_in[k]  = r_stg[k-1];
            assign w_vin[k] = r_vld[k-1];
        end

        // Stage may advance when empty or when the one after moves
        assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];

        // Try one root bit: subtract when the remainder covers it
        assign w_trial = {1'b0, w_in[k].res} + {1'b0, BIT};
        assign w_ge    = ({1'b0, w_in[k].rem} >= w_trial);

        assign n_stg[k].rem  = w_ge ? (w_in[k].rem - w_trial[RAD_W-1:0]) : w_in[k].rem;
        assign n_stg[k].res  = w_ge ? ((w_in[k].res >> 1) + BIT) : (w_in[k].res >> 1);
        assign n_stg[k].sat  = w_in[k].sat;
        assign n_stg[k].side = w_in[k].side;

        // Advance the valid bit
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_vld[k] <= w_vin[k];
            end
        end

        // Load the stage data on a transfer
        always_ff @(posedge i_clk) begin
            if (w_rdy[k] && w_vin[k]) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    // Clamp the root when the radicand was out of range
    assign o_valid = r_vld[STAGES-1];
    assign o_root  = r_stg[STAGES-1].sat ? ROOT_MAX : r_stg[STAGES-1].res[ROOT_W-1:0];
    assign o_side  = r_stg[STAGES-1].side;

    `QXRM_ASSERT(a_rem_bound, r_vld[STAGES-1] |-> ({1'b0, r_stg[STAGES-1].rem} <= ({1'b0, r_stg[STAGES-1].res} << 1)), "square root remainder exceeds twice the root")
    `QXRM_ASSERT(a_root_width, r_vld[STAGES-1] |-> (r_stg[STAGES-1].res[RAD_W-1:ROOT_W] == '0), "square root result wider than its field")

endmodule

`default_nettype wire

### sv/quat_xyz_to_rotation_matrix.sv
// Unit quaternion (x, y, z) to rotation matrix, fully pipelined top level.
//
// Input channel: i_valid, o_stall, payload i_qx, i_qy, i_qz (signed, FRAC_BITS
// fraction bits). A transfer takes place at a rising edge with i_valid high and
// o_stall low. Output channel: o_valid, i_stall, payload o_qw and o_m00..o_m22;
// a transfer takes place with o_valid high and i_stall low.
// Each item yields one result: w rebuilt as floor(sqrt(|1 - (x2+y2+z2)|)) and
// the nine rotation matrix entries, all clamped to their field ranges.
// The item passes 20 registers: three stages of products, sum of squares and
// radicand, fifteen square root stages (one root bit each), then the w
// products and the final sums with clamping. Throughput is one item per cycle
// while the receiver does not stall; the square root pipeline sets the depth.
// Every stage has its own valid bit and moves when the stage after it has
// room, so while the receiver stalls the pipeline keeps filling its bubbles
// and raises o_stall only once every stage holds an item.
// Reset (i_rst_n low at a clock edge) empties all stages; no state is kept
// between items.
`default_nettype none
`include "assert_macros.svh"

module quat_xyz_to_rotation_matrix
    import qxrm_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic signed [IN_W-1:0] i_qx,
    input  wire logic signed [IN_W-1:0] i_qy,
    input  wire logic signed [IN_W-1:0] i_qz,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic [ROOT_W-1:0]           o_qw,
    output logic signed [IN_W-1:0]      o_m00,
    output logic signed [IN_W-1:0]      o_m01,
    output logic signed [IN_W-1:0]      o_m02,
    output logic signed [IN_W-1:0]      o_m10,
    output logic signed [IN_W-1:0]      o_m11,
    output logic signed [IN_W-1:0]      o_m12,
    output logic signed [IN_W-1:0]      o_m20,
    output logic signed [IN_W-1:0]      o_m21,
    output logic signed [IN_W-1:0]      o_m22
);

    localparam int SH = FRAC_BITS - 1;
    localparam int DW = (2 * FRAC_BITS + 2 > SUM_W) ? 2 * FRAC_BITS + 2 : SUM_W;
    localparam logic [DW-1:0] UNIT2 = DW'(1) << (2 * FRAC_BITS);
    localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1) << FRAC_BITS;

    // Doubled product brought back to FRAC_BITS fraction bits, rounded down
    function automatic logic signed [SUM_W-1:0] f_dprod(input logic signed [PROD_W-1:0] p);
        logic signed [SUM_W-1:0] e;
        e = {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
        return e >>> SH;
    endfunction

    // Stage 1: products of the input parts
    logic  r_vld1;
    t_side r1_side;
    t_side n1_side;
    // Stage 2: sum of squares
    logic              r_vld2;
    logic [PROD_W-1:0] r2_sq;
    logic [PROD_W-1:0] n2_sq;
    t_side             r2_side;
    // Stage 3: radicand and range flag
    logic              r_vld3;
    logic [RAD_W-1:0]  r3_rad;
    logic              r3_sat;
    t_side             r3_side;
    logic [DW-1:0]     w_diff;
    logic [DW-1:0]     w_abs;
    // Square root pipeline outputs
    logic              w_sq_rdy;
    logic              w_sq_vld;
    logic [ROOT_W-1:0] w_root;
    t_side             w_sq_side;
    // Stage 4: w products
    logic                     r_vld4;
    logic [ROOT_W-1:0]        r4_w;
    logic signed [PROD_W-1:0] r4_pwx;
    logic signed [PROD_W-1:0] r4_pwy;
    logic signed [PROD_W-1:0] r4_pwz;
    t_side                    r4_side;
    logic signed [PROD_W-1:0] n4_pwx;
    logic signed [PROD_W-1:0] n4_pwy;
    logic signed [PROD_W-1:0] n4_pwz;
    // Stage 5: output register
    logic                     r_vld5;
    logic [ROOT_W-1:0]        r5_qw;
    logic signed [IN_W-1:0]   r5_m [9];
    logic signed [IN_W-1:0]   n5_m [9];
    logic signed [SUM_W-1:0]  w_xx, w_yy, w_zz, w_xy, w_xz, w_yz, w_wx, w_wy, w_wz;
    // Stage readiness
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;

    // Ripple readiness back from the output register
    assign w_rdy5  = !r_vld5 || !i_stall;
    assign w_rdy4  = !r_vld4 || w_rdy5;
    assign w_rdy3  = !r_vld3 || w_sq_rdy;
    assign w_rdy2  = !r_vld2 || w_rdy3;
    assign w_rdy1  = !r_vld1 || w_rdy2;
    assign o_stall = !w_rdy1;

    // Form the six raw products of the input parts
    assign n1_side.x    = i_qx;
    assign n1_side.y    = i_qy;
    assign n1_side.z    = i_qz;
    assign n1_side.p_xx = i_qx * i_qx;
    assign n1_side.p_yy = i_qy * i_qy;
    assign n1_side.p_zz = i_qz * i_qz;
    assign n1_side.p_xy = i_qx * i_qy;
    assign n1_side.p_xz = i_qx * i_qz;
    assign n1_side.p_yz = i_qy * i_qz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else if (w_rdy1) begin
            r_vld1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r1_side <= n1_side;
        end
    end

    // Sum the squares; each is non-negative and the total stays below 2^32
    assign n2_sq = $unsigned(r1_side.p_xx) + $unsigned(r1_side.p_yy)
                 + $unsigned(r1_side.p_zz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
        end else if (w_rdy2) begin
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_vld1) begin
            r2_sq   <= n2_sq;
            r2_side <= r1_side;
        end
    end

    // Take |1 - sum|; a radicand of 2^30 or more gives a root that clamps
    assign w_diff = UNIT2 - {{(DW-PROD_W){1'b0}}, r2_sq};
    assign w_abs  = w_diff[DW-1] ? -w_diff : w_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
        end else if (w_rdy3) begin
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r_vld2) begin
            r3_rad  <= w_abs[RAD_W-1:0];
            r3_sat  <= |w_abs[DW-1:RAD_W];
            r3_side <= r2_side;
        end
    end

    qxrm_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld3),
        .o_ready (w_sq_rdy),
        .i_rad   (r3_rad),
        .i_sat   (r3_sat),
        .i_side  (r3_side),
        .o_valid (w_sq_vld),
        .i_ready (w_rdy4),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    // Multiply the rebuilt w by each part
    assign n4_pwx = $signed({1'b0, w_root}) * w_sq_side.x;
    assign n4_pwy = $signed({1'b0, w_root}) * w_sq_side.y;
    assign n4_pwz = $signed({1'b0, w_root}) * w_sq_side.z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
        end else if (w_rdy4) begin
            r_vld4 <= w_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4 && w_sq_vld) begin
            r4_w    <= w_root;
            r4_pwx  <= n4_pwx;
            r4_pwy  <= n4_pwy;
            r4_pwz  <= n4_pwz;
            r4_side <= w_sq_side;
        end
    end

    // Scale the doubled products and build the matrix entries
    assign w_xx = f_dprod(r4_side.p_xx);
    assign w_yy = f_dprod(r4_side.p_yy);
    assign w_zz = f_dprod(r4_side.p_zz);
    assign w_xy = f_dprod(r4_side.p_xy);
    assign w_xz = f_dprod(r4_side.p_xz);
    assign w_yz = f_dprod(r4_side.p_yz);
    assign w_wx = f_dprod(r4_pwx);
    assign w_wy = f_dprod(r4_pwy);
    assign w_wz = f_dprod(r4_pwz);

    assign n5_m[0] = sat16(ONE - (w_yy + w_zz));
    assign n5_m[1] = sat16(w_xy - w_wz);
    assign n5_m[2] = sat16(w_xz + w_wy);
    assign n5_m[3] = sat16(w_xy + w_wz);
    assign n5_m[4] = sat16(ONE - (w_xx + w_zz));
    assign n5_m[5] = sat16(w_yz - w_wx);
    assign n5_m[6] = sat16(w_xz - w_wy);
    assign n5_m[7] = sat16(w_yz + w_wx);
    assign n5_m[8] = sat16(ONE - (w_xx + w_yy));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld5 <= 1'b0;
        end else if (w_rdy5) begin
            r_vld5 <= r_vld4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy5 && r_vld4) begin
            r5_qw <= r4_w;
            r5_m  <= n5_m;
        end
    end

    // Drive the output channel from the final register
    assign o_valid = r_vld5;
    assign o_qw    = r5_qw;
    assign o_m00   = r5_m[0];
    assign o_m01   = r5_m[1];
    assign o_m02   = r5_m[2];
    assign o_m10   = r5_m[3];
    assign o_m11   = r5_m[4];
    assign o_m12   = r5_m[5];
    assign o_m20   = r5_m[6];
    assign o_m21   = r5_m[7];
    assign o_m22   = r5_m[8];

    `QXRM_ASSERT(a_stall_only_full, o_stall |-> (r_vld1 && r_vld2 && r_vld3 && !w_sq_rdy), "input stalled with a free front stage")
    `QXRM_ASSERT(a_bubble_fill, (r_vld2 && !r_vld3) |=> r_vld3, "radicand stage failed to fill a bubble")
    `QXRM_ASSERT(a_w_hold, (r_vld4 && !w_rdy5) |=> (r_vld4 && $stable(r4_w)), "w product stage lost its item under stall")

endmodule

`default_nettype wire
